>>> rtl/gcp_pkg.sv
package gcp_pkg;

    // Fixed field widths of the item and result transactions, and of a degree count.
    localparam int W  = 64;
    localparam int VW = 6;
    localparam int DW = 7;

    // Default graph size.
    localparam int VERTICES_DEF = 64;

    // Function codes carried by an input transaction.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_PART = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_row;
        logic start;
        logic issue;
        logic pick;
        logic emit;
        logic emit_empty;
    } gcp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic pipe_busy;
        logic possible_zero;
        logic remaining_zero;
        logic cand_zero;
        logic out_free;
    } gcp_sts_t;

endpackage

>>> rtl/gcp_if.sv
interface gcp_item_if;
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic [gcp_pkg::VW-1:0]  row_index;
    logic [gcp_pkg::W-1:0]   row_mask;
    logic [gcp_pkg::W-1:0]   candidate_set;

    modport source (output valid, func, row_index, row_mask, candidate_set, input ready);
    modport sink   (input valid, func, row_index, row_mask, candidate_set, output ready);
endinterface

interface gcp_result_if;
    logic                    valid;
    logic                    ready;
    logic [gcp_pkg::W-1:0]   group_mask;
    logic [gcp_pkg::VW-1:0]  group_index;
    logic                    last;
    logic                    empty_res;

    modport source (output valid, group_mask, group_index, last, empty_res, input ready);
    modport sink   (input valid, group_mask, group_index, last, empty_res, output ready);
endinterface

>>> rtl/gcp_ctrl.sv
module gcp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_func,
    output logic              item_ready,
    input  gcp_pkg::gcp_sts_t sts,
    output gcp_pkg::gcp_cmd_t cmd
);
    import gcp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_PICK  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_EMPTY = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (item_func == FUNC_LOAD))
                begin
                    cmd.load_row = 1'b1;
                end
                else if (accept)
                begin
                    cmd.start  = 1'b1;
                    state_next = sts.cand_zero ? S_EMPTY : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = sts.possible_zero ? S_EMIT : S_SCAN;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.remaining_zero ? S_IDLE : S_SCAN;
                end
            end
            S_EMPTY:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/gcp_datapath.sv
module gcp_datapath #(
    parameter int VERTICES = gcp_pkg::VERTICES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [gcp_pkg::VW-1:0]  row_index,
    input  logic [gcp_pkg::W-1:0]   row_mask,
    input  logic [gcp_pkg::W-1:0]   candidate_set,
    input  gcp_pkg::gcp_cmd_t       cmd,
    output gcp_pkg::gcp_sts_t       sts,
    gcp_result_if.source            results
);
    import gcp_pkg::*;

    localparam int AW = $clog2(VERTICES);
    localparam logic [W-1:0] VMASK = {W{1'b1}} >> (W - VERTICES);

    // Population count as a tree of independent adds per level.
    function automatic logic [DW-1:0] popcount(input logic [W-1:0] x);
        logic [1:0] l1 [32];
        logic [2:0] l2 [16];
        logic [3:0] l3 [8];
        logic [4:0] l4 [4];
        logic [5:0] l5 [2];
        for (int i = 0; i < 32; i++)
        begin
            l1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
        end
        for (int i = 0; i < 16; i++)
        begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
        end
        return {1'b0, l5[0]} + {1'b0, l5[1]};
    endfunction

    // Adjacency memory with a valid bit per row; an unwritten row reads as zero.
    logic [W-1:0]          adj_mem [VERTICES];
    logic [VERTICES-1:0]   row_vld_reg;

    logic [W-1:0]  remaining_reg;
    logic [W-1:0]  possible_reg;
    logic [W-1:0]  group_reg;
    logic [VW-1:0] grp_cnt_reg;
    logic [AW-1:0] addr_reg;

    // Scan pipeline.
    logic          s1_act_reg;
    logic [VW-1:0] s1_idx_reg;
    logic [W-1:0]  s1_row_reg;
    logic          s1_vld_reg;
    logic          s2_act_reg;
    logic [VW-1:0] s2_idx_reg;
    logic [W-1:0]  s2_row_reg;
    logic [DW-1:0] s2_deg_reg;

    // Best candidate of the current scan.
    logic          found_reg;
    logic [VW-1:0] best_vertex_reg;
    logic [DW-1:0] best_degree_reg;
    logic [W-1:0]  best_row_reg;

    // Output register.
    logic          out_vld_reg;
    logic [W-1:0]  out_group_reg;
    logic [VW-1:0] out_idx_reg;
    logic          out_last_reg;
    logic          out_empty_reg;

    logic          row_in_range;
    logic [W-1:0]  cand_masked;
    logic [W-1:0]  s1_row_eff;
    logic [W-1:0]  pick_bit;
    logic          take_best;
    logic          out_load;

    assign row_in_range = ({1'b0, row_index} < (VW + 1)'(VERTICES));
    assign cand_masked  = candidate_set & VMASK;
    assign s1_row_eff   = s1_vld_reg ? s1_row_reg : '0;
    assign pick_bit     = W'(1) << best_vertex_reg;
    assign take_best    = s2_act_reg && (!found_reg || (s2_deg_reg > best_degree_reg));
    assign out_load     = cmd.emit || cmd.emit_empty;

    assign sts.scan_last      = (addr_reg == AW'(VERTICES - 1));
    assign sts.pipe_busy      = s1_act_reg || s2_act_reg;
    assign sts.possible_zero  = (possible_reg == '0);
    assign sts.remaining_zero = (remaining_reg == '0);
    assign sts.cand_zero      = (cand_masked == '0);
    assign sts.out_free       = !out_vld_reg || results.ready;

    assign results.valid       = out_vld_reg;
    assign results.group_mask  = out_group_reg;
    assign results.group_index = out_idx_reg;
    assign results.last        = out_last_reg;
    assign results.empty_res   = out_empty_reg;

    // Memory write on a row load and registered read during a scan.
    always_ff @(posedge clk)
    begin
        if (cmd.load_row && row_in_range)
        begin
            adj_mem[row_index[AW-1:0]] <= row_mask & VMASK & ~(W'(1) << row_index);
        end
        s1_row_reg <= adj_mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            s1_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_row && row_in_range)
            begin
                row_vld_reg[row_index[AW-1:0]] <= 1'b1;
            end
            s1_vld_reg <= row_vld_reg[addr_reg];
        end
    end

    // Pipeline control and the working sets.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_act_reg    <= 1'b0;
            s2_act_reg    <= 1'b0;
            found_reg     <= 1'b0;
            addr_reg      <= '0;
            remaining_reg <= '0;
            possible_reg  <= '0;
            group_reg     <= '0;
            grp_cnt_reg   <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            s1_act_reg <= cmd.issue;
            s2_act_reg <= s1_act_reg && possible_reg[s1_idx_reg];

            if (cmd.issue)
            begin
                addr_reg <= addr_reg + AW'(1);
            end

            if (take_best)
            begin
                found_reg <= 1'b1;
            end

            if (cmd.start)
            begin
                remaining_reg <= cand_masked;
                possible_reg  <= cand_masked;
                group_reg     <= '0;
                grp_cnt_reg   <= '0;
                addr_reg      <= '0;
                found_reg     <= 1'b0;
            end
            else if (cmd.pick)
            begin
                group_reg     <= group_reg | pick_bit;
                remaining_reg <= remaining_reg & ~pick_bit;
                possible_reg  <= possible_reg & ~pick_bit & best_row_reg;
                addr_reg      <= '0;
                found_reg     <= 1'b0;
            end
            else if (cmd.emit)
            begin
                possible_reg <= remaining_reg;
                group_reg    <= '0;
                grp_cnt_reg  <= grp_cnt_reg + VW'(1);
                addr_reg     <= '0;
                found_reg    <= 1'b0;
            end

            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Pipeline payload, best candidate and result payload.
    always_ff @(posedge clk)
    begin
        s1_idx_reg <= VW'(addr_reg);
        s2_idx_reg <= s1_idx_reg;
        s2_row_reg <= s1_row_eff;
        s2_deg_reg <= popcount(s1_row_eff & possible_reg);

        if (take_best)
        begin
            best_vertex_reg <= s2_idx_reg;
            best_degree_reg <= s2_deg_reg;
            best_row_reg    <= s2_row_reg;
        end

        if (cmd.emit)
        begin
            out_group_reg <= group_reg;
            out_idx_reg   <= grp_cnt_reg;
            out_last_reg  <= (remaining_reg == '0);
            out_empty_reg <= 1'b0;
        end
        else if (cmd.emit_empty)
        begin
            out_group_reg <= '0;
            out_idx_reg   <= '0;
            out_last_reg  <= 1'b1;
            out_empty_reg <= 1'b1;
        end
    end

    // A group never overlaps the vertices still to be placed.
    a_group_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (group_reg & remaining_reg) == '0)
        else $error("group overlaps remaining set");

    // The possible set stays inside the remaining set.
    a_possible_subset: assert property (@(posedge clk) disable iff (!rst_n)
        (possible_reg & ~remaining_reg) == '0)
        else $error("possible set leaves remaining set");

    // A pick always follows a scan that found a candidate.
    a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pick |-> found_reg)
        else $error("pick without a candidate");

    // A real group result is never empty.
    a_group_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (out_group_reg != '0) && !out_empty_reg)
        else $error("empty group emitted");

endmodule

>>> rtl/greedy_clique_partition_top.sv
// Load transaction: accepted only while idle, produces no result.
// Partition transaction: each vertex pick scans every row, and a group is emitted
// once no vertex can still join it; the transaction ends when no vertex remains.
// One start is handled at a time; the scan pipeline and its memory read set the rate.
// Reset is asynchronous and active low; it clears every row's valid bit at once,
// so the graph reads as all zero at once, with no clearing pass.
module greedy_clique_partition_top #(
    parameter int VERTICES = gcp_pkg::VERTICES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    gcp_item_if.sink   items,
    gcp_result_if.source results
);
    import gcp_pkg::*;

    gcp_cmd_t cmd;
    gcp_sts_t sts;
    logic     ready_w;

    assign items.ready = ready_w;

    gcp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (items.valid),
        .item_func  (items.func),
        .item_ready (ready_w),
        .sts        (sts),
        .cmd        (cmd)
    );

    gcp_datapath #(
        .VERTICES (VERTICES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .row_index     (items.row_index),
        .row_mask      (items.row_mask),
        .candidate_set (items.candidate_set),
        .cmd           (cmd),
        .sts           (sts),
        .results       (results)
    );

endmodule
